// ===== rtl/core/eor_pkg.sv =====
// Package for the ellipse outline rasterizer: status codes, opcodes, defaults.
// No dependencies.
package eor_pkg;

   localparam int CoordBitsDefault = 16;
   localparam int FracBitsDefault  = 6;

   typedef enum logic [2:0] {
      ST_PIXEL   = 3'd0,
      ST_STARTED = 3'd1,
      ST_NOPIX   = 3'd2,
      ST_NEGRAD  = 3'd3,
      ST_ZERORAD = 3'd4,
      ST_IDLE    = 3'd5
   } status_type;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

endpackage

// ===== rtl/core/ellipse_outline_rasterizer.sv =====
// Ellipse outline rasterizer top level: sequencer, state and output register.
// Depends on eor_pkg and eor_div.
// Start, error and idle-step transactions: result registered in the cycle after acceptance.
// Step: a multiply step, then 4 divisions in turn on the shared divider of width DW
// (DW = 2*COORD_BITS+5, 37 by default), then one result per cycle (up to 8) unless
// the output register is held by rsp_ready.
// Synchronous active-high reset returns the block to idle with no ellipse.
module ellipse_outline_rasterizer #(
   parameter int COORD_BITS = eor_pkg::CoordBitsDefault,
   parameter int FRAC_BITS  = eor_pkg::FracBitsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic signed [COORD_BITS-1:0] req_radius_x,
   input  logic signed [COORD_BITS-1:0] req_radius_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last,
   output logic                         rsp_done_res
);
   import eor_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int RB = C + FRAC_BITS + 2;
   localparam int HW = RB - FRAC_BITS + 1;   // rounded coordinate width
   localparam int DW = HW + C + 2;           // divider width
   localparam int PW = DW;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_DJ, S_DK, S_WK, S_DA, S_WA, S_DB, S_WB, S_EMIT, S_OUT
   } state_type;

   state_type state_ff;
   logic active_ff, major_x_ff;
   logic signed [C-1:0]  ccol_ff, crow_ff;
   logic [C-2:0]         rh_ff, rv_ff;
   logic signed [RB-1:0] rot_a_ff, rot_b_ff;
   logic signed [HW-1:0] pf_ff, ps_ff;
   logic pf_ok_ff, ps_ok_ff;
   logic signed [HW-1:0] h_ff, i_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [HW-1:0] j_ff, k_ff;
   logic [2:0]  idx_ff, cnt_ff;
   logic        fin_ff;
   logic        busy_ff;
   // output register
   logic        ov_ff, ov_in;
   logic [2:0]  ost_ff;
   logic signed [C-1:0] ox_ff, oy_ff;
   logic        olast_ff, odone_ff;

   // shared divider
   logic               dstart;
   logic signed [DW-1:0] ddend, dq;
   logic        [DW-1:0] dsor;
   logic               dbusy;
   eor_div #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(ddend),
      .divisor(dsor), .busy(dbusy), .quotient(dq));

   logic [C-2:0] major, minor;
   assign major = major_x_ff ? rh_ff : rv_ff;
   assign minor = major_x_ff ? rv_ff : rh_ff;
   assign dsor  = DW'(major);

   logic signed [RB-1:0] rnd_a, rnd_b;
   assign rnd_a = rot_a_ff + RB'(1 << (FRAC_BITS - 1));
   assign rnd_b = rot_b_ff + RB'(1 << (FRAC_BITS - 1));
   logic signed [HW-1:0] h_c, i_c;
   assign h_c = HW'(rnd_a >>> FRAC_BITS);
   assign i_c = HW'(rnd_b >>> FRAC_BITS);

   // go test
   logic go;
   always_comb begin
      if (major_x_ff)
         go = ((!pf_ok_ff || pf_ff != k_ff) && (!ps_ok_ff || ps_ff != k_ff))
           || ((!ps_ok_ff || ps_ff != j_ff) && (!pf_ok_ff || pf_ff != j_ff))
           || (k_ff != j_ff);
      else
         go = ((!pf_ok_ff || pf_ff != i_ff) && (!ps_ok_ff || ps_ff != i_ff))
           || ((!ps_ok_ff || ps_ff != h_ff) && (!pf_ok_ff || pf_ff != h_ff)
               && (i_ff != h_ff));
   end

   // pixel for emission index: groups (dx,dy) in file order
   logic signed [HW-1:0] dx, dy;
   logic [2:0] g1n;
   logic [1:0] sub;
   logic signed [C-1:0] px, py;
   always_comb begin
      logic signed [HW-1:0] dx1, dy1, dx2, dy2;
      if (major_x_ff) begin
         dx1 = h_ff; dy1 = k_ff; dx2 = i_ff; dy2 = j_ff;
      end else begin
         dx1 = j_ff; dy1 = i_ff; dx2 = k_ff; dy2 = h_ff;
      end
      g1n = (dy1 > 0) ? 3'd4 : 3'd2;
      if (idx_ff < g1n) begin
         dx = dx1; dy = dy1; sub = idx_ff[1:0];
      end else begin
         dx = dx2; dy = dy2; sub = 2'(idx_ff - g1n);
      end
      px = sub[0] ? ccol_ff + C'(dx) : ccol_ff - C'(dx);
      if (dy > 0) py = sub[1] ? crow_ff - C'(dy) : crow_ff + C'(dy);
      else        py = crow_ff;
   end
   logic [3:0] total;
   assign total = {1'b0, g1n} + (((major_x_ff ? j_ff : h_ff) > 0) ? 4'd4 : 4'd2);

   logic out_free;
   assign out_free  = !ov_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   logic acc;
   assign acc = req_valid && req_ready;

   // divider launches: one start cycle per division
   always_comb begin
      dstart = 1'b0;
      ddend  = '0;
      unique case (state_ff)
         S_DJ: begin dstart = 1'b1; ddend = prod_ff; end
         S_WK: begin dstart = 1'b1; ddend = DW'(i_ff * $signed({1'b0, minor})); end
         S_WA: begin dstart = 1'b1; ddend = DW'(rot_b_ff); end
         S_WB: begin dstart = 1'b1; ddend = DW'(rot_a_ff); end
         default: ;
      endcase
   end

   // output valid: set on a new result, cleared when taken
   always_comb begin
      ov_in = ov_ff && !rsp_ready;
      if (state_ff == S_IDLE && acc && !(req_op == OP_STEP && active_ff)) ov_in = 1'b1;
      if (state_ff == S_OUT && out_free) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= 1'b0; major_x_ff <= 1'b0;
         ccol_ff <= '0; crow_ff <= '0; rh_ff <= '0; rv_ff <= '0;
         rot_a_ff <= '0; rot_b_ff <= '0;
         pf_ok_ff <= 1'b0; ps_ok_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         unique case (state_ff)
            S_IDLE: if (acc) begin
               olast_ff <= 1'b1; odone_ff <= 1'b0; ox_ff <= '0; oy_ff <= '0;
               if (req_op == OP_START) begin
                  if (req_radius_x < 0 || req_radius_y < 0) begin
                     active_ff <= 1'b0;
                     ost_ff <= ST_NEGRAD;
                  end else if (req_radius_x == 0 || req_radius_y == 0) begin
                     active_ff <= 1'b0;
                     ost_ff <= ST_ZERORAD;
                  end else begin
                     ost_ff <= ST_STARTED;
                     ccol_ff <= req_center_x; crow_ff <= req_center_y;
                     rh_ff <= req_radius_x[C-2:0]; rv_ff <= req_radius_y[C-2:0];
                     major_x_ff <= req_radius_x > req_radius_y;
                     rot_a_ff <= '0;
                     rot_b_ff <= (req_radius_x > req_radius_y)
                        ? RB'(req_radius_x) <<< FRAC_BITS
                        : RB'(req_radius_y) <<< FRAC_BITS;
                     pf_ok_ff <= 1'b0; ps_ok_ff <= 1'b0;
                     active_ff <= 1'b1;
                  end
               end else if (!active_ff) begin
                  ost_ff <= ST_IDLE;
               end else begin
                  h_ff <= h_c; i_ff <= i_c;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= PW'(h_ff * $signed({1'b0, minor}));
               fin_ff   <= !(i_ff > h_ff);
               state_ff <= S_DJ;
            end
            S_DJ: state_ff <= S_DK;
            S_DK: if (!dbusy) begin j_ff <= HW'(dq); state_ff <= S_WK; end
            S_WK: state_ff <= S_DA;
            S_DA: if (!dbusy) begin k_ff <= HW'(dq); state_ff <= S_WA; end
            S_WA: state_ff <= S_DB;
            S_DB: if (!dbusy) begin
               rot_a_ff <= rot_a_ff + RB'(dq);
               state_ff <= S_WB;
            end
            S_WB: state_ff <= S_EMIT;
            S_EMIT: if (!dbusy) begin
               rot_b_ff <= rot_b_ff - RB'(dq);
               idx_ff <= '0;
               cnt_ff <= go ? 3'(total - 1'b1) : '0;
               busy_ff <= go;
               if (go) begin
                  pf_ff <= major_x_ff ? k_ff : i_ff; pf_ok_ff <= 1'b1;
                  ps_ff <= major_x_ff ? j_ff : h_ff; ps_ok_ff <= 1'b1;
               end
               if (fin_ff) active_ff <= 1'b0;
               state_ff <= S_OUT;
            end
            S_OUT: if (out_free) begin
               ost_ff <= busy_ff ? ST_PIXEL : ST_NOPIX;
               ox_ff <= busy_ff ? px : '0;
               oy_ff <= busy_ff ? py : '0;
               olast_ff <= idx_ff == cnt_ff;
               odone_ff <= (idx_ff == cnt_ff) && fin_ff;
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == cnt_ff) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = ov_ff;
   assign rsp_status   = ost_ff;
   assign rsp_pixel_x  = ox_ff;
   assign rsp_pixel_y  = oy_ff;
   assign rsp_last     = olast_ff;
   assign rsp_done_res = odone_ff;

   a_busy : assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("ready while working");
   a_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_last)
      else $error("done without last");
   a_fin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_ready |-> !active_ff)
      else $error("active after final iteration");
endmodule

// ===== rtl/core/eor_div.sv =====
// Shared restoring divider, one quotient bit per cycle, truncating signed result.
// Depends on eor_pkg.
module eor_div #(
   parameter int W = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] dividend,
   input  logic        [W-1:0] divisor,
   output logic                busy,
   output logic signed [W-1:0] quotient
);
   import eor_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    trial;

   // one shift-subtract step per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[W-1] ? W'(-dividend) : dividend;
         neg_in  = dividend[W-1];
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? W'(-quo_ff) : quo_ff;

   a_cnt : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == CW'(1) |=> !busy_ff)
      else $error("divider did not finish");
   a_go : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && cnt_ff == CW'(W))
      else $error("divider did not start");
   a_nz : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider count underflow");
endmodule
